// ----- sv/prmd_pkg.sv -----
// Package for the planar run-length marker decoder.
// Holds the sizes, status codes and the structs shared by the channel queue and the top level.
// Depends on nothing.
`default_nettype none

package prmd_pkg;

  // Sizes of the block.
  localparam int QueueDepth   = 4;
  localparam int ChannelCount = 4;
  localparam int ShownCount   = 4;
  localparam int WordW        = 32;
  localparam int ChanW        = 2;
  localparam int PtrW         = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int FillW        = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] MarkerReset = 32'hFFFF_FFFF;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotReady = 2'd2
  } status_e;

  // Request kinds.
  localparam logic ReqPush = 1'b0;
  localparam logic ReqPull = 1'b1;

  // Control from the top level to one channel.
  typedef struct packed {
    logic             push;
    logic             pull;
    logic [WordW-1:0] word;
    logic [WordW-1:0] marker;
  } chan_ctrl_t;

  // Status from one channel to the top level.
  typedef struct packed {
    logic             nonempty;
    logic             drop;
    logic [WordW-1:0] head_value;
  } chan_stat_t;

endpackage

`default_nettype wire

// ----- sv/prmd_if.sv -----
// Handshake interfaces for the request and result channels of the decoder.
// Depends on prmd_pkg for field widths.
`default_nettype none

// Request channel: push of a coded word or pull of one pixel.
interface prmd_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [prmd_pkg::ChanW-1:0] channel;
  logic [prmd_pkg::WordW-1:0] coded_word;

  modport source (output valid, req_type, channel, coded_word, input ready);
  modport sink   (input valid, req_type, channel, coded_word, output ready);
endinterface

// Result channel: status and the four decoded channel words.
interface prmd_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [prmd_pkg::WordW-1:0] chan_zero;
  logic [prmd_pkg::WordW-1:0] chan_one;
  logic [prmd_pkg::WordW-1:0] chan_two;
  logic [prmd_pkg::WordW-1:0] chan_three;

  modport source (output valid, status, chan_zero, chan_one, chan_two, chan_three,
                  input ready);
  modport sink   (input valid, status, chan_zero, chan_one, chan_two, chan_three,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/planar_rle_marker_decoder.sv -----
// Planar run-length marker decoder: one compressed stream per channel, pixels out.
// Depends on prmd_pkg, the prmd_req_if and prmd_rsp_if interfaces and prmd_chan.
//
// Each request item either pushes one coded word into a channel's parser or pulls
// one pixel built from the head run of every channel; every item gives exactly one
// result item. An item is registered on acceptance and resolved into the result
// register once that register is free, so the block takes one item per cycle while
// the result side does not stall. The escape marker resets to all ones; it is to be
// written only while the block is idle, and the block itself does not enforce this.
`default_nettype none

module planar_rle_marker_decoder (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [prmd_pkg::WordW-1:0] cfg_wdata_i,
  prmd_req_if.sink                        req_i,
  prmd_rsp_if.source                      rsp_o
);

  logic [prmd_pkg::WordW-1:0] marker_q;

  logic                       in_vld_q, in_vld_d;
  logic                       in_type_q;
  logic [prmd_pkg::ChanW-1:0] in_chan_q;
  logic [prmd_pkg::WordW-1:0] in_word_q;

  logic                       out_vld_q, out_vld_d;
  prmd_pkg::status_e          status_q, status_d;
  logic [prmd_pkg::WordW-1:0] chan_q [prmd_pkg::ShownCount];
  logic [prmd_pkg::WordW-1:0] chan_d [prmd_pkg::ShownCount];

  logic                       advance;
  logic                       accept;
  logic                       fire;
  logic                       all_ready;
  logic                       any_drop;
  logic                       pull_ok;

  prmd_pkg::chan_ctrl_t       ctrl [prmd_pkg::ChannelCount];
  prmd_pkg::chan_stat_t       stat [prmd_pkg::ChannelCount];
  logic [prmd_pkg::ChannelCount-1:0] nonempty_vec;
  logic [prmd_pkg::ChannelCount-1:0] drop_vec;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= prmd_pkg::MarkerReset;
    end else if (cfg_we_i) begin
      marker_q <= cfg_wdata_i;
    end
  end

  // Handshake: the input stage moves on whenever the result register is free.
  assign advance     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !in_vld_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign fire        = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_type_q <= req_i.req_type;
      in_chan_q <= req_i.channel;
      in_word_q <= req_i.coded_word;
    end
  end

  assign all_ready = &nonempty_vec;
  assign any_drop  = |drop_vec;
  assign pull_ok   = (in_type_q == prmd_pkg::ReqPull) && all_ready;

  // One parser and run queue per channel.
  for (genvar c = 0; c < prmd_pkg::ChannelCount; c++) begin : g_chan
    assign ctrl[c].push   = fire && (in_type_q == prmd_pkg::ReqPush) &&
                            (32'(in_chan_q) == c);
    assign ctrl[c].pull   = fire && pull_ok;
    assign ctrl[c].word   = in_word_q;
    assign ctrl[c].marker = marker_q;
    assign nonempty_vec[c] = stat[c].nonempty;
    assign drop_vec[c]     = stat[c].drop;

    prmd_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[c]),
      .stat_o (stat[c])
    );
  end

  // Result words: the head value of each shown channel on a good pull, else zero.
  for (genvar k = 0; k < prmd_pkg::ShownCount; k++) begin : g_shown
    if (k < prmd_pkg::ChannelCount) begin : g_live
      assign chan_d[k] = pull_ok ? stat[k].head_value : '0;
    end else begin : g_none
      assign chan_d[k] = '0;
    end
  end

  always_comb begin
    if (in_type_q == prmd_pkg::ReqPull) begin
      status_d = all_ready ? prmd_pkg::StOk : prmd_pkg::StNotReady;
    end else begin
      status_d = any_drop ? prmd_pkg::StFull : prmd_pkg::StOk;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      chan_q   <= chan_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.chan_zero  = chan_q[0];
  assign rsp_o.chan_one   = chan_q[1];
  assign rsp_o.chan_two   = chan_q[2];
  assign rsp_o.chan_three = chan_q[3];

  // A held item in the input stage is not overwritten while the result is stalled.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_word_q) && $stable(in_type_q))
    else $error("input stage lost a stalled item");

  // Every resolved item shows up in the result register.
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("resolved item missing from result register");

  // A pull with every queue nonempty reports success.
  a_pull_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pull_ok |=> status_q == prmd_pkg::StOk)
    else $error("good pull reported a failure status");

endmodule

`default_nettype wire

// ----- sv/prmd_chan.sv -----
// One channel of the decoder: marker parser and the run queue of that channel.
// Depends on prmd_pkg for sizes and the control and status structs.
`default_nettype none

module prmd_chan (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire prmd_pkg::chan_ctrl_t ctrl_i,
  output prmd_pkg::chan_stat_t      stat_o
);

  localparam logic [1:0] PhaseToken = 2'd0;
  localparam logic [1:0] PhaseValue = 2'd1;
  localparam logic [1:0] PhaseCount = 2'd2;

  logic [1:0]                   phase_q, phase_d;
  logic [prmd_pkg::WordW-1:0]   pending_q, pending_d;
  logic [prmd_pkg::PtrW-1:0]    head_q, head_d;
  logic [prmd_pkg::FillW-1:0]   fill_q, fill_d;
  logic [prmd_pkg::WordW-1:0]   val_mem [prmd_pkg::QueueDepth];
  logic [prmd_pkg::WordW-1:0]   left_mem [prmd_pkg::QueueDepth];

  logic                         enq_req;
  logic                         full;
  logic                         enq_do;
  logic [prmd_pkg::WordW-1:0]   enq_value;
  logic [prmd_pkg::WordW-1:0]   enq_count;
  logic [prmd_pkg::FillW:0]     tail_sum;
  logic [prmd_pkg::FillW:0]     tail_wrap;
  logic [prmd_pkg::PtrW-1:0]    tail_idx;
  logic [prmd_pkg::WordW-1:0]   head_left;
  logic                         head_done;

  assign full = (fill_q == prmd_pkg::FillW'(prmd_pkg::QueueDepth));

  // Parser: a marker word opens a value/count triple, any other word is a literal.
  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    enq_req   = 1'b0;
    enq_value = ctrl_i.word;
    enq_count = {{(prmd_pkg::WordW-1){1'b0}}, 1'b1};
    if (ctrl_i.push) begin
      case (phase_q)
        PhaseValue: begin
          pending_d = ctrl_i.word;
          phase_d   = PhaseCount;
        end
        PhaseCount: begin
          enq_req   = 1'b1;
          enq_value = pending_q;
          if (ctrl_i.word != '0) begin
            enq_count = ctrl_i.word;
          end
          phase_d   = PhaseToken;
        end
        default: begin
          if (ctrl_i.word == ctrl_i.marker) begin
            phase_d = PhaseValue;
          end else begin
            enq_req = 1'b1;
            phase_d = PhaseToken;
          end
        end
      endcase
    end
  end

  assign enq_do = enq_req && !full;

  // Tail slot is head plus fill, wrapped once around the queue.
  always_comb begin
    tail_sum  = (prmd_pkg::FillW+1)'(head_q) + (prmd_pkg::FillW+1)'(fill_q);
    tail_wrap = tail_sum;
    if (tail_sum >= (prmd_pkg::FillW+1)'(prmd_pkg::QueueDepth)) begin
      tail_wrap = tail_sum - (prmd_pkg::FillW+1)'(prmd_pkg::QueueDepth);
    end
    tail_idx = tail_wrap[prmd_pkg::PtrW-1:0];
  end

  // Head run: counted down on a pull and popped once its last pixel goes out.
  assign head_left = left_mem[head_q];
  assign head_done = (head_left <= {{(prmd_pkg::WordW-1){1'b0}}, 1'b1});

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (enq_do) begin
      fill_d = fill_q + 1'b1;
    end else if (ctrl_i.pull && head_done) begin
      fill_d = fill_q - 1'b1;
      if (head_q == prmd_pkg::PtrW'(prmd_pkg::QueueDepth - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhaseToken;
      pending_q <= '0;
      head_q    <= '0;
      fill_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
    end
  end

  // Run storage, written on enqueue and on count down.
  always_ff @(posedge clk_i) begin
    if (enq_do) begin
      val_mem[tail_idx]  <= enq_value;
      left_mem[tail_idx] <= enq_count;
    end else if (ctrl_i.pull && !head_done) begin
      left_mem[head_q] <= head_left - 1'b1;
    end
  end

  assign stat_o.nonempty   = (fill_q != '0);
  assign stat_o.drop       = enq_req && full;
  assign stat_o.head_value = val_mem[head_q];

  // The fill count never passes the queue depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= prmd_pkg::FillW'(prmd_pkg::QueueDepth))
    else $error("queue fill beyond depth");

  // A dropped run leaves the queue as it was.
  a_drop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.drop |=> $stable(fill_q) && $stable(head_q))
    else $error("dropped run changed the queue");

  // A pull only reaches a channel that holds a run.
  a_pull_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pull |-> fill_q != '0)
    else $error("pull on an empty queue");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the planar run-length marker decoder.
// Depends on prmd_pkg, the prmd_req_if and prmd_rsp_if interfaces and the
// planar_rle_marker_decoder top level.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseCount    = 5;
  localparam int PhaseItems    = 160;
  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 4;
  localparam int WatchdogLimit = 4000;

  // Parser state of one channel stream.
  typedef enum logic [1:0] {
    PhToken = 2'd0,
    PhValue = 2'd1,
    PhCount = 2'd2
  } parse_ph_e;

  typedef struct packed {
    logic                       req;
    logic [prmd_pkg::ChanW-1:0] ch;
    logic [prmd_pkg::WordW-1:0] word;
  } dec_req_t;

  typedef struct packed {
    prmd_pkg::status_e          status;
    logic [prmd_pkg::WordW-1:0] c0;
    logic [prmd_pkg::WordW-1:0] c1;
    logic [prmd_pkg::WordW-1:0] c2;
    logic [prmd_pkg::WordW-1:0] c3;
  } pixel_t;

  typedef struct {
    dec_req_t rq;
    bit       typed;
    pixel_t   want;
  } dir_row_t;

  localparam pixel_t OkPx       = '{prmd_pkg::StOk, 32'h0, 32'h0, 32'h0, 32'h0};
  localparam pixel_t FullPx     = '{prmd_pkg::StFull, 32'h0, 32'h0, 32'h0, 32'h0};
  localparam pixel_t NotReadyPx = '{prmd_pkg::StNotReady, 32'h0, 32'h0, 32'h0, 32'h0};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [prmd_pkg::WordW-1:0] cfg_wdata;

  prmd_req_if req_if ();
  prmd_rsp_if rsp_if ();

  planar_rle_marker_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Predicted decoder state.
  logic [prmd_pkg::WordW-1:0] esc_marker;
  parse_ph_e                  parse_st  [prmd_pkg::ChannelCount];
  logic [prmd_pkg::WordW-1:0] held_value[prmd_pkg::ChannelCount];
  logic [prmd_pkg::WordW-1:0] run_val   [prmd_pkg::ChannelCount][prmd_pkg::QueueDepth];
  logic [prmd_pkg::WordW-1:0] run_cnt   [prmd_pkg::ChannelCount][prmd_pkg::QueueDepth];
  int                         q_head    [prmd_pkg::ChannelCount];
  int                         q_fill    [prmd_pkg::ChannelCount];

  pixel_t   pixel_q[$];
  dir_row_t dir_tab[$];
  bit       next_typed;
  pixel_t   next_want;
  int       mismatches;
  int       idle_cycles;
  bit       rx_random;
  bit       hold_request;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Puts a finished run into the channel queue, or reports the queue full.
  function automatic prmd_pkg::status_e store_run(input int ch,
                                                  input logic [prmd_pkg::WordW-1:0] value,
                                                  input logic [prmd_pkg::WordW-1:0] count);
    int slot;
    if (q_fill[ch] >= prmd_pkg::QueueDepth) return prmd_pkg::StFull;
    slot = (q_head[ch] + q_fill[ch]) % prmd_pkg::QueueDepth;
    run_val[ch][slot] = value;
    run_cnt[ch][slot] = (count == '0) ? 32'd1 : count;
    q_fill[ch]++;
    return prmd_pkg::StOk;
  endfunction

  // Works out the result of one accepted item and advances the predicted state.
  function automatic pixel_t decode_request(input dec_req_t rq);
    pixel_t                     res;
    int                         ch;
    int                         h;
    bit                         all_ready;
    logic [prmd_pkg::WordW-1:0] shown[prmd_pkg::ShownCount];
    res = OkPx;
    shown = '{default: '0};
    if (rq.req == prmd_pkg::ReqPush) begin
      ch = int'(rq.ch);
      if (ch < prmd_pkg::ChannelCount) begin
        case (parse_st[ch])
          PhValue: begin
            held_value[ch] = rq.word;
            parse_st[ch] = PhCount;
          end
          PhCount: begin
            res.status = store_run(ch, held_value[ch], rq.word);
            parse_st[ch] = PhToken;
          end
          default: begin
            if (rq.word == esc_marker) begin
              parse_st[ch] = PhValue;
            end else begin
              res.status = store_run(ch, rq.word, 32'd1);
              parse_st[ch] = PhToken;
            end
          end
        endcase
      end
    end else begin
      all_ready = 1'b1;
      for (int i = 0; i < prmd_pkg::ChannelCount; i++) begin
        if (q_fill[i] == 0) all_ready = 1'b0;
      end
      if (!all_ready) begin
        res.status = prmd_pkg::StNotReady;
      end else begin
        // Every channel gives its head run and counts it down.
        for (int i = 0; i < prmd_pkg::ChannelCount; i++) begin
          h = q_head[i];
          if (i < prmd_pkg::ShownCount) shown[i] = run_val[i][h];
          if (run_cnt[i][h] <= 1) begin
            run_cnt[i][h] = '0;
            q_head[i] = (h + 1) % prmd_pkg::QueueDepth;
            q_fill[i]--;
          end else begin
            run_cnt[i][h] = run_cnt[i][h] - 1;
          end
        end
        res.c0 = shown[0];
        res.c1 = shown[1];
        res.c2 = shown[2];
        res.c3 = shown[3];
      end
    end
    return res;
  endfunction

  function automatic dir_row_t tab_row(input logic req,
                                       input logic [prmd_pkg::ChanW-1:0] ch,
                                       input logic [prmd_pkg::WordW-1:0] word,
                                       input bit typed, input pixel_t want);
    dir_row_t r;
    r.rq    = '{req, ch, word};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A literal word, biased toward the extremes, never equal to the marker.
  function automatic logic [prmd_pkg::WordW-1:0] literal_word();
    logic [prmd_pkg::WordW-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      default: w = $urandom;
    endcase
    if (w == esc_marker) w = ~w;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [prmd_pkg::WordW-1:0] want,
                             input logic [prmd_pkg::WordW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Offers one item at the falling edge and holds it until it is accepted.
  // The expected result of the item is published together with the item.
  task automatic send_req(input dec_req_t rq, input int gap, input bit typed = 1'b0,
                          input pixel_t want = OkPx);
    @(negedge clk_i);
    next_typed        = typed;
    next_want         = want;
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rq.req;
    req_if.channel    <= rq.ch;
    req_if.coded_word <= rq.word;
    do @(posedge clk_i); while (!req_if.ready);
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid      <= 1'b0;
      req_if.coded_word <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_marker(input logic [prmd_pkg::WordW-1:0] m);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    esc_marker = m;
  endtask

  // Result receiver: always ready, random stalls, or one long hold-off.
  initial begin : rx_proc
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (!rx_random) begin
        rsp_if.ready <= 1'b1;
      end else if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Checks results against the oldest prediction, predicts accepted items,
  // and ends the run when nothing moves for too long.
  always @(posedge clk_i) begin : monitor
    pixel_t want;
    pixel_t got;
    bit     req_acc;
    bit     rsp_acc;
    req_acc = rst_ni && req_if.valid && req_if.ready;
    rsp_acc = rst_ni && rsp_if.valid && rsp_if.ready;
    if (rsp_acc) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item outstanding, got status %0d", $time,
                 rsp_if.status);
      end else begin
        want = pixel_q.pop_front();
        check_field("status", prmd_pkg::WordW'(want.status),
                    prmd_pkg::WordW'(rsp_if.status));
        check_field("chan_zero", want.c0, rsp_if.chan_zero);
        check_field("chan_one", want.c1, rsp_if.chan_one);
        check_field("chan_two", want.c2, rsp_if.chan_two);
        check_field("chan_three", want.c3, rsp_if.chan_three);
      end
    end
    if (req_acc) begin
      got = decode_request('{req_if.req_type, req_if.channel, req_if.coded_word});
      pixel_q.push_back(next_typed ? next_want : got);
    end
    if (req_acc || rsp_acc) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("planar_rle_marker_decoder: mismatch");
      $finish;
    end
  end

  // Stimulus.
  initial begin : stim
    int                         sent;
    int                         pull_pct;
    int                         ch;
    bit                         gaps_on;
    logic [prmd_pkg::WordW-1:0] m;
    logic [prmd_pkg::WordW-1:0] w;

    mismatches        = 0;
    idle_cycles       = 0;
    rx_random         = 1'b1;
    hold_request      = 1'b0;
    next_typed        = 1'b0;
    next_want         = OkPx;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = prmd_pkg::ReqPush;
    req_if.channel    = '0;
    req_if.coded_word = '0;

    // Predictor reset.
    esc_marker = prmd_pkg::MarkerReset;
    for (int i = 0; i < prmd_pkg::ChannelCount; i++) begin
      parse_st[i]   = PhToken;
      held_value[i] = '0;
      q_head[i]     = 0;
      q_fill[i]     = 0;
      for (int j = 0; j < prmd_pkg::QueueDepth; j++) begin
        run_val[i][j] = '0;
        run_cnt[i][j] = '0;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    set_marker(prmd_pkg::MarkerReset);

    // Directed part: empty pull, marker as value, zero count, queue full.
    dir_tab.push_back(tab_row(prmd_pkg::ReqPull, 2'd0, 32'h0000_0000, 1'b1, NotReadyPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'h0000_0000, 1'b1, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd1, 32'hFFFF_FFFF, 1'b1, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd1, 32'hFFFF_FFFF, 1'b1, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd1, 32'h0000_0000, 1'b1, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd2, 32'h1234_5678, 1'b1, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPull, 2'd3, 32'hFFFF_FFFF, 1'b1, NotReadyPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd3, 32'hFFFF_FFFF, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd3, 32'hA5A5_A5A5, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd3, 32'h0000_0003, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPull, 2'd0, 32'h0000_0000, 1'b1,
                              '{prmd_pkg::StOk, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678,
                                32'hA5A5_A5A5}));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPull, 2'd0, 32'h0000_0000, 1'b1, NotReadyPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'hFFFF_FFFE, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'h8000_0000, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'h7FFF_FFFF, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'h0000_0001, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'h5A5A_5A5A, 1'b1, FullPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'hFFFF_FFFF, 1'b1, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'h1111_1111, 1'b1, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd0, 32'h0000_0002, 1'b1, FullPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd1, 32'h0F0F_0F0F, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd2, 32'hF0F0_F0F0, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPull, 2'd1, 32'h0000_0000, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPull, 2'd2, 32'h0000_0000, 1'b0, OkPx));
    dir_tab.push_back(tab_row(prmd_pkg::ReqPush, 2'd1, 32'h0000_0000, 1'b0, OkPx));

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].rq, pick_gap(), dir_tab[i].typed, dir_tab[i].want);
    end
    wait_idle();

    // Random phases, each with its own marker, pull rate and idling mix.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       m = '0;
        1:       m = '1;
        2:       m = 32'h8000_0000;
        3:       m = $urandom;
        default: m = 32'h0000_0001;
      endcase
      set_marker(m);
      case (p)
        0:       pull_pct = 35;
        1:       pull_pct = 20;
        2:       pull_pct = 50;
        3:       pull_pct = 35;
        default: pull_pct = 60;
      endcase
      rx_random = (p != 3);
      gaps_on   = (p != 1) && (p != 3);
      // Long receiver hold-off with the sender offering back to back.
      if (p == 1) hold_request = 1'b1;

      sent = 0;
      while (sent < PhaseItems) begin
        ch = $urandom_range(0, prmd_pkg::ChannelCount - 1);
        if ($urandom_range(0, 99) < pull_pct) begin
          send_req('{prmd_pkg::ReqPull, prmd_pkg::ChanW'($urandom),
                     prmd_pkg::WordW'($urandom)},
                   gaps_on ? pick_gap() : 0);
          sent++;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              send_req('{prmd_pkg::ReqPush, prmd_pkg::ChanW'(ch), literal_word()},
                       gaps_on ? pick_gap() : 0);
              sent++;
            end
            5, 6, 7, 8: begin
              // Marker, value and count to one channel.
              send_req('{prmd_pkg::ReqPush, prmd_pkg::ChanW'(ch), esc_marker},
                       gaps_on ? pick_gap() : 0);
              w = ($urandom_range(0, 7) == 0) ? esc_marker : literal_word();
              send_req('{prmd_pkg::ReqPush, prmd_pkg::ChanW'(ch), w},
                       gaps_on ? pick_gap() : 0);
              w = ($urandom_range(0, 9) == 0) ? prmd_pkg::WordW'($urandom_range(7, 40))
                                              : prmd_pkg::WordW'($urandom_range(0, 6));
              send_req('{prmd_pkg::ReqPush, prmd_pkg::ChanW'(ch), w},
                       gaps_on ? pick_gap() : 0);
              sent += 3;
            end
            default: begin
              // Noise: a lone marker or any word, which may break a triple.
              w = $urandom_range(0, 1) ? esc_marker : prmd_pkg::WordW'($urandom);
              send_req('{prmd_pkg::ReqPush, prmd_pkg::ChanW'(ch), w},
                       gaps_on ? pick_gap() : 0);
              sent++;
            end
          endcase
        end
      end
      wait_idle();
    end

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("planar_rle_marker_decoder: match");
    end else begin
      $display("planar_rle_marker_decoder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
